// File: hw/rtl/lbp_histogram_core_defines.svh
// assertion macros shared by the lbp histogram rtl
// expects clk and rst_n in the scope of each use
`ifndef LBP_HISTOGRAM_CORE_DEFINES_SVH
`define LBP_HISTOGRAM_CORE_DEFINES_SVH

// same-cycle implication
`define LBP_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/lbp_pkg.sv
// constants, opcodes and the stage request type for the lbp histogram core
// no dependencies
package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int CFG_W      = 11;
  localparam int EW         = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
  localparam int WIDTH_MIN  = 3;
  localparam int PIX_W      = 8;
  localparam int BIN_W      = 8;
  localparam int NUM_BINS   = 1 << BIN_W;
  localparam int COUNT_BITS = 20;
  localparam int OP_W       = 2;
  localparam int IN_DATA_W  = PIX_W + BIN_W;
  localparam int OUT_DATA_W = ((COUNT_BITS + 7) / 8) * 8;

  localparam logic [CFG_W-1:0]      WIDTH_RESET = CFG_W'(640);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_PIXEL = 2'd0,
    OP_READ  = 2'd1,
    OP_START = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    logic             vld;
    op_t              op;
    logic [BIN_W-1:0] addr;
  } hist_req_t;

endpackage

// File: hw/rtl/lbp_line_buf.sv
// line stores, 3x3 window and code generation for the lbp histogram core
// depends on lbp_pkg
module lbp_line_buf
  import lbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_acc,
  input  op_t              in_op,
  input  logic [PIX_W-1:0] in_pixel,
  input  logic [BIN_W-1:0] in_bin,
  input  logic [CFG_W-1:0] cfg_width,
  output hist_req_t        req
);

  localparam logic [1:0] ROWS_FULL = 2'd2;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [1:0]       rows_r, rows_nxt;

  logic             s1_vld_r;
  op_t              s1_op_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [BIN_W-1:0] s1_bin_r;
  logic [COL_W-1:0] s1_idx_r;
  logic             s1_int_r;
  logic [PIX_W-1:0] top_rd_r;
  logic [PIX_W-1:0] mid_rd_r;
  logic [PIX_W-1:0] win_r [6];

  logic [EW-1:0]    cfg_ext, eff_w, col_inc;
  logic             row_end;
  logic             interior;
  logic [PIX_W-1:0] ctr;
  logic [BIN_W-1:0] code;
  logic             s1_pix_go, s1_start_go;

  always_comb begin
    cfg_ext = EW'(cfg_width);
    if (cfg_ext < EW'(WIDTH_MIN)) begin
      eff_w = EW'(WIDTH_MIN);
    end else if (cfg_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = cfg_ext;
    end
    col_inc  = EW'(col_r) + EW'(1);
    row_end  = (col_inc >= eff_w);
    interior = (rows_r == ROWS_FULL) && (col_r >= COL_W'(2));

    col_nxt  = col_r;
    rows_nxt = rows_r;
    if (in_acc && in_op == OP_PIXEL) begin
      if (row_end) begin
        col_nxt = '0;
        if (rows_r != ROWS_FULL) begin
          rows_nxt = rows_r + 2'd1;
        end
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end else if (in_acc && in_op == OP_START) begin
      col_nxt  = '0;
      rows_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      rows_r   <= '0;
      s1_vld_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      rows_r <= rows_nxt;
      if (adv) begin
        s1_vld_r <= in_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_op;
      s1_pix_r <= in_pixel;
      s1_bin_r <= in_bin;
      s1_idx_r <= col_r;
      s1_int_r <= interior;
    end
  end

  assign s1_pix_go   = adv && s1_vld_r && s1_op_r == OP_PIXEL;
  assign s1_start_go = adv && s1_vld_r && s1_op_r == OP_START;

  // line stores: read at accept, written back as the item leaves stage one
  always_ff @(posedge clk) begin
    if (in_acc) begin
      top_rd_r <= upper_mem[col_r];
      mid_rd_r <= middle_mem[col_r];
    end
    if (s1_pix_go) begin
      upper_mem[s1_idx_r]  <= mid_rd_r;
      middle_mem[s1_idx_r] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_start_go) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_pix_go) begin
      win_r[0] <= win_r[1];
      win_r[1] <= top_rd_r;
      win_r[2] <= win_r[3];
      win_r[3] <= mid_rd_r;
      win_r[4] <= win_r[5];
      win_r[5] <= s1_pix_r;
    end
  end

  always_comb begin
    ctr  = win_r[3];
    code = {win_r[2] > ctr, mid_rd_r > ctr, win_r[1] > ctr, win_r[5] > ctr,
            win_r[0] > ctr, top_rd_r > ctr, win_r[4] > ctr, s1_pix_r > ctr};
    req.op = s1_op_r;
    case (s1_op_r)
      OP_READ: begin
        req.vld  = s1_vld_r;
        req.addr = s1_bin_r;
      end
      OP_START: begin
        req.vld  = s1_vld_r;
        req.addr = code;
      end
      OP_PIXEL: begin
        req.vld  = s1_vld_r && s1_int_r;
        req.addr = code;
      end
      default: begin
        req.vld  = 1'b0;
        req.addr = code;
      end
    endcase
  end

endmodule

// File: hw/rtl/lbp_hist.sv
// histogram memory with read-modify-write, forwarding and result register
// depends on lbp_pkg and lbp_histogram_core_defines.svh
`include "lbp_histogram_core_defines.svh"
module lbp_hist
  import lbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  hist_req_t             req,
  input  logic                  out_tready,
  output logic                  adv,
  output logic                  out_tvalid,
  output logic [COUNT_BITS-1:0] out_count
);

  logic [COUNT_BITS-1:0] hist_mem [NUM_BINS];
  logic [NUM_BINS-1:0]   bin_vld_r;

  logic                  s2_vld_r;
  op_t                   s2_op_r;
  logic [BIN_W-1:0]      s2_addr_r;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  rd_vld_r;
  logic                  fwd_vld_r;
  logic [BIN_W-1:0]      fwd_addr_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic                  out_vld_r;
  logic [COUNT_BITS-1:0] out_count_r;

  logic [COUNT_BITS-1:0] cur, inc;
  logic                  wr_en, clr, rd_go;

  assign adv   = !(s2_vld_r && s2_op_r == OP_READ && out_vld_r && !out_tready);
  assign wr_en = adv && s2_vld_r && s2_op_r == OP_PIXEL;
  assign clr   = adv && s2_vld_r && s2_op_r == OP_START;
  assign rd_go = adv && s2_vld_r && s2_op_r == OP_READ;

  always_comb begin
    if (fwd_vld_r && fwd_addr_r == s2_addr_r) begin
      cur = fwd_data_r;
    end else if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
    inc = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_data_r <= hist_mem[req.addr];
      rd_vld_r  <= bin_vld_r[req.addr] && !clr;
      s2_op_r   <= req.op;
      s2_addr_r <= req.addr;
    end
    if (wr_en) begin
      hist_mem[s2_addr_r] <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
      s2_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        bin_vld_r <= '0;
      end else if (wr_en) begin
        bin_vld_r[s2_addr_r] <= 1'b1;
      end
      if (adv) begin
        s2_vld_r  <= req.vld;
        fwd_vld_r <= wr_en;
      end
      if (out_vld_r && out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (rd_go) begin
        out_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr_r <= s2_addr_r;
      fwd_data_r <= inc;
    end
    if (rd_go) begin
      out_count_r <= cur;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_count  = out_count_r;

  `LBP_ASSERT_IMPL(a_stall_only_on_read, !adv, s2_vld_r && s2_op_r == OP_READ && out_vld_r, "stall without a waiting read item")
  `LBP_ASSERT_NEXT(a_start_clears_bins, clr, bin_vld_r == '0, "bins not cleared by start")
  `LBP_ASSERT_NEXT(a_fwd_tracks_write, wr_en, fwd_vld_r && fwd_addr_r == $past(s2_addr_r), "forward register lost a write")

endmodule

// File: hw/rtl/lbp_histogram_core.sv
// lbp histogram core: an accepted read item passes stage one, stage two and the result register before out_tvalid
// throughput one item per cycle; the input stalls only while a read result waits
// in the output register and the next read item reaches the last stage
// reset (synchronous, rst_n low): position counters, window and all 256 bins zero,
// image width 640; bins cleared at once through valid bits, no clearing pass
// line stores hold undefined data until written; depends on lbp_line_buf, lbp_hist
module lbp_histogram_core
  import lbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pixel, bin_index
  input  logic [OP_W-1:0]       in_tuser,   // opcode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // bin_count, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_W-1:0]      cfg_data
);

  logic [CFG_W-1:0]      width_r;
  logic                  adv;
  logic                  in_acc;
  hist_req_t             req;
  logic [COUNT_BITS-1:0] out_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_valid) begin
      width_r <= cfg_data;
    end
  end

  assign in_tready = adv;
  assign in_acc    = in_tvalid && adv;

  lbp_line_buf u_line_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_acc    (in_acc),
    .in_op     (op_t'(in_tuser)),
    .in_pixel  (in_tdata[PIX_W-1:0]),
    .in_bin    (in_tdata[PIX_W +: BIN_W]),
    .cfg_width (width_r),
    .req       (req)
  );

  lbp_hist u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .out_tready (out_tready),
    .adv        (adv),
    .out_tvalid (out_tvalid),
    .out_count  (out_count)
  );

  assign out_tdata = OUT_DATA_W'(out_count);

endmodule
